// ----- hw/rtl/swdh_pkg.sv -----
// Package: SWD host packet engine codes, constants and shared types.
package swdh_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_RESET = 2'd3;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_HDR    = 4'd1;
    localparam logic [3:0] PH_TURN1  = 4'd2;
    localparam logic [3:0] PH_ACK    = 4'd3;
    localparam logic [3:0] PH_RDATA  = 4'd4;
    localparam logic [3:0] PH_TURN2  = 4'd5;
    localparam logic [3:0] PH_WDATA  = 4'd6;
    localparam logic [3:0] PH_TRAIL  = 4'd7;
    localparam logic [3:0] PH_RHIGH1 = 4'd8;
    localparam logic [3:0] PH_SWITCH = 4'd9;
    localparam logic [3:0] PH_RHIGH2 = 4'd10;
    localparam logic [3:0] PH_RLOW   = 4'd11;

    localparam int DEF_READ_TRAILER_CLOCKS  = 3;
    localparam int DEF_WRITE_TRAILER_CLOCKS = 20;
    localparam int DEF_RESET_HIGH_CLOCKS    = 60;

    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] HDR_BITS    = 7'd8;
    localparam logic [COUNT_W-1:0] TURN_BITS   = 7'd1;
    localparam logic [COUNT_W-1:0] ACK_BITS    = 7'd3;
    localparam logic [COUNT_W-1:0] DATA_BITS   = 7'd33;
    localparam logic [COUNT_W-1:0] SWITCH_BITS = 7'd16;
    localparam logic [COUNT_W-1:0] RLOW_BITS   = 7'd3;

    localparam logic [15:0] SWITCH_SEQ = 16'hE79E;

    typedef struct packed {
        logic [1:0]  op;
        logic        port_ap;
        logic [1:0]  reg_addr;
        logic [31:0] write_data;
        logic        swdio_in;
    } swdh_item_t;

    typedef struct packed {
        logic        swdio_out;
        logic        swdio_drive;
        logic        clock_pulse;
        logic        busy_res;
        logic        done_res;
        logic [2:0]  ack;
        logic [31:0] read_data;
    } swdh_result_t;

endpackage

// ----- hw/rtl/swdh_engine.sv -----
// Bit-period sequencer: state registers and next-period logic of the SWD host.
module swdh_engine #(
    parameter int READ_TRAILER_CLOCKS  = swdh_pkg::DEF_READ_TRAILER_CLOCKS,
    parameter int WRITE_TRAILER_CLOCKS = swdh_pkg::DEF_WRITE_TRAILER_CLOCKS,
    parameter int RESET_HIGH_CLOCKS    = swdh_pkg::DEF_RESET_HIGH_CLOCKS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  swdh_pkg::swdh_item_t item,
    input  logic                 jtag_switch_enable,
    output swdh_pkg::swdh_result_t result
);
    import swdh_pkg::*;

    localparam logic [COUNT_W-1:0] READ_TRAIL_LEN  = COUNT_W'(READ_TRAILER_CLOCKS);
    localparam logic [COUNT_W-1:0] WRITE_TRAIL_LEN = COUNT_W'(WRITE_TRAILER_CLOCKS);
    localparam logic [COUNT_W-1:0] RESET_HIGH_LEN  = COUNT_W'(RESET_HIGH_CLOCKS);

    logic [3:0]         phase_reg, phase_next;
    logic [COUNT_W-1:0] bit_count_reg, bit_count_next;
    logic [1:0]         kind_reg;
    logic [7:0]         header_reg, header_next;
    logic [32:0]        tx_reg, tx_next;
    logic [32:0]        rx_reg, rx_next;
    logic [2:0]         ack_reg, ack_next;

    logic               start;
    logic               active;
    logic [1:0]         kind_eff;
    logic [3:0]         phase_eff;
    logic [COUNT_W-1:0] count_eff;
    logic [COUNT_W-1:0] count_inc;
    logic [7:0]         header_eff;
    logic [32:0]        tx_eff;
    logic [32:0]        rx_eff;
    logic [2:0]         ack_eff;
    logic               hdr_par;
    logic [COUNT_W-1:0] trail_len;
    logic [COUNT_W-1:0] phase_len;
    logic [3:0]         phase_after;
    logic               last_bit;
    logic               done;
    logic               level;
    logic               drive;

    assign start  = (phase_reg == PH_IDLE);
    assign active = !start || (item.op != OP_TICK);

    assign hdr_par    = ^{item.port_ap, (item.op == OP_READ), item.reg_addr};
    assign kind_eff   = start ? item.op : kind_reg;
    assign count_eff  = start ? '0 : bit_count_reg;
    assign count_inc  = count_eff + COUNT_W'(1);
    assign header_eff = start ? {1'b1, 1'b0, hdr_par, item.reg_addr,
                                 (item.op == OP_READ), item.port_ap, 1'b1}
                              : header_reg;
    assign tx_eff     = start ? ((item.op == OP_WRITE)
                                 ? {^item.write_data, item.write_data} : 33'd0)
                              : tx_reg;
    assign rx_eff     = start ? 33'd0 : rx_reg;
    assign ack_eff    = start ? 3'd0 : ack_reg;
    assign trail_len  = (kind_eff == OP_READ) ? READ_TRAIL_LEN : WRITE_TRAIL_LEN;

    always_comb
    begin
        if (!start)
            phase_eff = phase_reg;
        else if (item.op == OP_RESET)
            phase_eff = jtag_switch_enable ? PH_RHIGH1 : PH_RHIGH2;
        else
            phase_eff = PH_HDR;
    end

    always_comb
    begin
        level       = 1'b0;
        drive       = 1'b1;
        header_next = header_eff;
        tx_next     = tx_eff;
        rx_next     = rx_eff;
        ack_next    = ack_eff;
        unique case (phase_eff) inside
            PH_HDR:
            begin
                level       = header_eff[0];
                header_next = header_eff >> 1;
            end
            PH_TURN1, PH_TURN2:
            begin
                drive = 1'b0;
            end
            PH_ACK:
            begin
                drive    = 1'b0;
                ack_next = {item.swdio_in, ack_eff[2:1]};
            end
            PH_RDATA:
            begin
                drive   = 1'b0;
                rx_next = {item.swdio_in, rx_eff[32:1]};
            end
            PH_WDATA:
            begin
                level   = tx_eff[0];
                tx_next = tx_eff >> 1;
            end
            PH_RHIGH1, PH_RHIGH2:
            begin
                level = 1'b1;
            end
            PH_SWITCH:
            begin
                level = SWITCH_SEQ[count_eff[3:0]];
            end
            default:
            begin
                level = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (phase_eff) inside
            PH_HDR:               phase_len = HDR_BITS;
            PH_TURN1, PH_TURN2:   phase_len = TURN_BITS;
            PH_ACK:               phase_len = ACK_BITS;
            PH_RDATA, PH_WDATA:   phase_len = DATA_BITS;
            PH_TRAIL:             phase_len = trail_len;
            PH_RHIGH1, PH_RHIGH2: phase_len = RESET_HIGH_LEN;
            PH_SWITCH:            phase_len = SWITCH_BITS;
            PH_RLOW:              phase_len = RLOW_BITS;
            default:              phase_len = TURN_BITS;
        endcase
    end

    always_comb
    begin
        unique case (phase_eff) inside
            PH_HDR:              phase_after = PH_TURN1;
            PH_TURN1:            phase_after = PH_ACK;
            PH_ACK:              phase_after = (kind_eff == OP_READ) ? PH_RDATA : PH_TURN2;
            PH_TURN2:            phase_after = PH_WDATA;
            PH_RDATA, PH_WDATA:  phase_after = (trail_len == '0) ? PH_IDLE : PH_TRAIL;
            PH_RHIGH1:           phase_after = PH_SWITCH;
            PH_SWITCH:           phase_after = PH_RHIGH2;
            PH_RHIGH2:           phase_after = PH_RLOW;
            default:             phase_after = PH_IDLE;
        endcase
    end

    assign last_bit       = (count_inc >= phase_len);
    assign phase_next     = last_bit ? phase_after : phase_eff;
    assign bit_count_next = last_bit ? '0 : count_inc;
    assign done           = last_bit && (phase_after == PH_IDLE);

    always_comb
    begin
        result = '0;
        if (!active)
        begin
            result.swdio_drive = 1'b1;
        end
        else
        begin
            result.swdio_out   = drive & level;
            result.swdio_drive = drive;
            result.clock_pulse = 1'b1;
            result.busy_res    = 1'b1;
            result.done_res    = done;
            result.ack         = (done && kind_eff != OP_RESET) ? ack_next : 3'd0;
            result.read_data   = (done && kind_eff == OP_READ) ? rx_next[31:0] : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            kind_reg      <= OP_TICK;
        end
        else if (step_en && active)
        begin
            phase_reg     <= phase_next;
            bit_count_reg <= bit_count_next;
            kind_reg      <= kind_eff;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && active)
        begin
            header_reg <= header_next;
            tx_reg     <= tx_next;
            rx_reg     <= rx_next;
            ack_reg    <= ack_next;
        end
    end

endmodule

// ----- hw/rtl/swd_host_packet_engine_top.sv -----
// Top level: SWD host packet engine with input register, result register and config.
// Each accepted item is one SWD bit period and yields exactly one result item; the
// block takes one item per clock unless out_ready holds back the result register; each
// item is captured in the input register and then in the result register, around the
// combinational bit-period logic. A request (op 1, 2, 3) while idle starts a read,
// write or line reset in that same period; op is ignored until that sequence has
// ended.
// jtag_switch_enable is sampled when a line reset starts.
module swd_host_packet_engine_top #(
    parameter int READ_TRAILER_CLOCKS  = swdh_pkg::DEF_READ_TRAILER_CLOCKS,
    parameter int WRITE_TRAILER_CLOCKS = swdh_pkg::DEF_WRITE_TRAILER_CLOCKS,
    parameter int RESET_HIGH_CLOCKS    = swdh_pkg::DEF_RESET_HIGH_CLOCKS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic        port_ap,
    input  logic [1:0]  reg_addr,
    input  logic [31:0] write_data,
    input  logic        swdio_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        swdio_out,
    output logic        swdio_drive,
    output logic        clock_pulse,
    output logic        busy_res,
    output logic        done_res,
    output logic [2:0]  ack,
    output logic [31:0] read_data
);
    import swdh_pkg::*;

    logic         jtag_switch_enable_reg;
    logic         item_valid_reg, item_valid_next;
    swdh_item_t   item_reg;
    logic         result_valid_reg, result_valid_next;
    swdh_result_t result_reg;
    swdh_result_t step_result;
    logic         advance;
    logic         in_xfer;

    assign advance  = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    assign item_valid_next   = in_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
    assign result_valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : result_valid_reg);

    swdh_engine #(
        .READ_TRAILER_CLOCKS  (READ_TRAILER_CLOCKS),
        .WRITE_TRAILER_CLOCKS (WRITE_TRAILER_CLOCKS),
        .RESET_HIGH_CLOCKS    (RESET_HIGH_CLOCKS)
    ) u_engine (
        .clk                (clk),
        .rst_n              (rst_n),
        .step_en            (advance),
        .item               (item_reg),
        .jtag_switch_enable (jtag_switch_enable_reg),
        .result             (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jtag_switch_enable_reg <= 1'b0;
            item_valid_reg         <= 1'b0;
            result_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                jtag_switch_enable_reg <= cfg_write_data;
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            item_reg.op         <= op;
            item_reg.port_ap    <= port_ap;
            item_reg.reg_addr   <= reg_addr;
            item_reg.write_data <= write_data;
            item_reg.swdio_in   <= swdio_in;
        end
        if (advance)
            result_reg <= step_result;
    end

    assign out_valid   = result_valid_reg;
    assign swdio_out   = result_reg.swdio_out;
    assign swdio_drive = result_reg.swdio_drive;
    assign clock_pulse = result_reg.clock_pulse;
    assign busy_res    = result_reg.busy_res;
    assign done_res    = result_reg.done_res;
    assign ack         = result_reg.ack;
    assign read_data   = result_reg.read_data;

`ifndef ASSERT_OFF
    a_done_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (busy_res && clock_pulse))
        else $error("done outside a sequence");

    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (!clock_pulse && swdio_drive && !swdio_out))
        else $error("idle period not quiet");

    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !swdio_drive) |-> (!swdio_out && busy_res))
        else $error("released line driven high");

    a_ack_with_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((ack != 3'd0) || (read_data != 32'd0))) |-> done_res)
        else $error("ack or read data without done");
`endif

endmodule

// ----- verif/tb_swd_host_packet_engine_top.sv -----
// Testbench: drives SWD bit periods through the packet engine and checks each result transfer.
module tb_swd_host_packet_engine_top;
    timeunit 1ns;
    timeprecision 1ps;
    import swdh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD = 300;
    localparam int unsigned ITEMS_PER_PHASE = 30;
    localparam int SW_LOW = 0;
    localparam int SW_HIGH = 1;
    localparam int SW_RANDOM = 2;

    class swd_period_tracker;
        bit switch_en;
        logic [3:0] phase;
        logic [6:0] bit_cnt;
        logic [32:0] tx_word;
        logic [32:0] rx_word;
        logic [2:0] ack_bits;
        logic [1:0] kind;
        logic [7:0] header;
        bit with_switch;
        swdh_result_t pending_periods[$];
        int unsigned transfers, checked, errors;
        int unsigned reads, writes, resets, switch_resets;

        function new();
            switch_en = 1'b0;
            phase = PH_IDLE;
            bit_cnt = '0;
            tx_word = '0;
            rx_word = '0;
            ack_bits = '0;
            kind = OP_TICK;
            header = '0;
            with_switch = 1'b0;
        endfunction

        function int unsigned trailer_length();
            return (kind == OP_READ) ? DEF_READ_TRAILER_CLOCKS : DEF_WRITE_TRAILER_CLOCKS;
        endfunction

        function int unsigned phase_length(logic [3:0] p);
            case (p)
                PH_HDR: return HDR_BITS;
                PH_TURN1, PH_TURN2: return TURN_BITS;
                PH_ACK: return ACK_BITS;
                PH_RDATA, PH_WDATA: return DATA_BITS;
                PH_TRAIL: return trailer_length();
                PH_RHIGH1, PH_RHIGH2: return DEF_RESET_HIGH_CLOCKS;
                PH_SWITCH: return SWITCH_BITS;
                PH_RLOW: return RLOW_BITS;
                default: return 1;
            endcase
        endfunction

        function logic [3:0] phase_after(logic [3:0] p);
            logic [3:0] n;
            case (p)
                PH_HDR: n = PH_TURN1;
                PH_TURN1: n = PH_ACK;
                PH_ACK: n = (kind == OP_READ) ? PH_RDATA : PH_TURN2;
                PH_RDATA: n = PH_TRAIL;
                PH_TURN2: n = PH_WDATA;
                PH_WDATA: n = PH_TRAIL;
                PH_RHIGH1: n = PH_SWITCH;
                PH_SWITCH: n = PH_RHIGH2;
                PH_RHIGH2: n = PH_RLOW;
                default: n = PH_IDLE;
            endcase
            if (n == PH_TRAIL && trailer_length() == 0)
                n = PH_IDLE;
            return n;
        endfunction

        function swdh_result_t next_bit_period(swdh_item_t it);
            swdh_result_t r;
            logic [4:0] req;
            logic level, drive, done;
            r = '0;
            level = 1'b0;
            drive = 1'b1;
            done = 1'b0;
            if (phase == PH_IDLE) begin
                if (it.op == OP_TICK) begin
                    r.swdio_drive = 1'b1;
                    return r;
                end
                kind = it.op;
                bit_cnt = '0;
                ack_bits = '0;
                rx_word = '0;
                tx_word = '0;
                if (it.op == OP_RESET) begin
                    with_switch = switch_en;
                    phase = switch_en ? PH_RHIGH1 : PH_RHIGH2;
                end
                else begin
                    req = {it.reg_addr, it.op == OP_READ, it.port_ap, 1'b0};
                    header = {1'b1, 1'b0, ^req, req[4:1], 1'b1};
                    if (it.op == OP_WRITE)
                        tx_word = {^it.write_data, it.write_data};
                    phase = PH_HDR;
                end
            end
            case (phase)
                PH_HDR:
                begin
                    level = header[0];
                    header = header >> 1;
                end
                PH_TURN1, PH_TURN2: drive = 1'b0;
                PH_ACK:
                begin
                    drive = 1'b0;
                    ack_bits = {it.swdio_in, ack_bits[2:1]};
                end
                PH_RDATA:
                begin
                    drive = 1'b0;
                    rx_word = {it.swdio_in, rx_word[32:1]};
                end
                PH_WDATA:
                begin
                    level = tx_word[0];
                    tx_word = tx_word >> 1;
                end
                PH_RHIGH1, PH_RHIGH2: level = 1'b1;
                PH_SWITCH: level = SWITCH_SEQ[bit_cnt[3:0]];
                default: level = 1'b0;
            endcase
            bit_cnt = bit_cnt + 7'd1;
            if (bit_cnt >= phase_length(phase)) begin
                bit_cnt = '0;
                phase = phase_after(phase);
                done = (phase == PH_IDLE);
            end
            r.swdio_out = drive ? level : 1'b0;
            r.swdio_drive = drive;
            r.clock_pulse = 1'b1;
            r.busy_res = 1'b1;
            r.done_res = done;
            if (done) begin
                if (kind != OP_RESET)
                    r.ack = ack_bits;
                if (kind == OP_READ)
                    r.read_data = rx_word[31:0];
                case (kind)
                    OP_READ: reads++;
                    OP_WRITE: writes++;
                    default:
                    begin
                        resets++;
                        if (with_switch)
                            switch_resets++;
                    end
                endcase
            end
            return r;
        endfunction

        function void note_transfer(swdh_item_t it);
            transfers++;
            pending_periods.push_back(next_bit_period(it));
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            end
        endfunction

        function void check_result(swdh_result_t got);
            swdh_result_t want;
            if (pending_periods.size() == 0) begin
                errors++;
                $display("%0t: result with nothing pending, expected none actual %h", $time, got);
                return;
            end
            want = pending_periods.pop_front();
            checked++;
            compare("swdio_out", want.swdio_out, got.swdio_out);
            compare("swdio_drive", want.swdio_drive, got.swdio_drive);
            compare("clock_pulse", want.clock_pulse, got.clock_pulse);
            compare("busy_res", want.busy_res, got.busy_res);
            compare("done_res", want.done_res, got.done_res);
            compare("ack", want.ack, got.ack);
            compare("read_data", want.read_data, got.read_data);
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_write_en = 1'b0;
    logic cfg_write_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] op = OP_TICK;
    logic port_ap = 1'b0;
    logic [1:0] reg_addr = 2'd0;
    logic [31:0] write_data = 32'd0;
    logic swdio_in = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic swdio_out;
    logic swdio_drive;
    logic clock_pulse;
    logic busy_res;
    logic done_res;
    logic [2:0] ack;
    logic [31:0] read_data;

    swd_period_tracker tracker = new();
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int unsigned cycle_count = 0;

    swd_host_packet_engine_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write_en(cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .port_ap(port_ap),
        .reg_addr(reg_addr),
        .write_data(write_data),
        .swdio_in(swdio_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .swdio_out(swdio_out),
        .swdio_drive(swdio_drive),
        .clock_pulse(clock_pulse),
        .busy_res(busy_res),
        .done_res(done_res),
        .ack(ack),
        .read_data(read_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic swdh_item_t make_item(logic [1:0] code, int sw_mode);
        swdh_item_t it;
        it.op = code;
        it.port_ap = 1'($urandom);
        it.reg_addr = 2'($urandom);
        it.write_data = $urandom;
        it.swdio_in = (sw_mode == SW_RANDOM) ? 1'($urandom) : (sw_mode == SW_HIGH);
        return it;
    endfunction

    task automatic send_item(swdh_item_t it);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        port_ap <= it.port_ap;
        reg_addr <= it.reg_addr;
        write_data <= it.write_data;
        swdio_in <= it.swdio_in;
        do @(posedge clk); while (!in_ready);
        tracker.note_transfer(it);
    endtask

    task automatic start_request(logic [1:0] code, logic ap, logic [1:0] addr,
                                 logic [31:0] data, int sw_mode);
        swdh_item_t it;
        it = make_item(code, sw_mode);
        it.port_ap = ap;
        it.reg_addr = addr;
        it.write_data = data;
        send_item(it);
    endtask

    task automatic run_to_idle(int sw_mode, bit noisy);
        logic [1:0] code;
        while (tracker.phase != PH_IDLE) begin
            code = (noisy && $urandom_range(0, 3) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
            send_item(make_item(code, sw_mode));
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (tracker.pending_periods.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_switch(bit value);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        tracker.switch_en = value;
    endtask

    initial
    begin
        swdh_result_t got;
        int unsigned stall;
        @(posedge rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (hold_req) begin
                hold_req = 1'b0;
                stall = LONG_HOLD;
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.swdio_out = swdio_out;
            got.swdio_drive = swdio_drive;
            got.clock_pulse = clock_pulse;
            got.busy_res = busy_res;
            got.done_res = done_res;
            got.ack = ack;
            got.read_data = read_data;
            tracker.check_result(got);
        end
    end

    initial
    begin
        swdh_item_t it;
        logic [1:0] code;
        int unsigned phase_start;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        it = make_item(OP_TICK, SW_HIGH);
        it.port_ap = 1'b1;
        it.reg_addr = 2'd3;
        it.write_data = 32'hFFFF_FFFF;
        send_item(it);
        it = make_item(OP_TICK, SW_LOW);
        it.port_ap = 1'b0;
        it.reg_addr = 2'd0;
        it.write_data = 32'h0;
        send_item(it);

        start_request(OP_READ, 1'b1, 2'd3, $urandom, SW_HIGH);
        run_to_idle(SW_HIGH, 1'b0);
        start_request(OP_READ, 1'b0, 2'd0, $urandom, SW_LOW);
        run_to_idle(SW_LOW, 1'b1);
        start_request(OP_WRITE, 1'b1, 2'd2, 32'hFFFF_FFFF, SW_RANDOM);
        run_to_idle(SW_RANDOM, 1'b0);
        start_request(OP_WRITE, 1'b0, 2'd1, 32'h0, SW_RANDOM);
        run_to_idle(SW_RANDOM, 1'b1);
        start_request(OP_RESET, 1'b1, 2'd3, $urandom, SW_RANDOM);
        run_to_idle(SW_RANDOM, 1'b0);

        // change the switch setting while a line reset is still in its high phase
        wait_idle();
        write_switch(1'b1);
        start_request(OP_RESET, 1'b0, 2'd0, $urandom, SW_RANDOM);
        repeat (20) send_item(make_item(OP_TICK, SW_RANDOM));
        wait_idle();
        write_switch(1'b0);
        run_to_idle(SW_RANDOM, 1'b1);

        for (int p = 0; p < 4; p++) begin
            wait_idle();
            write_switch(p == 3 ? 1'($urandom_range(0, 1)) : (p % 2 == 0));
            steady = (p == 1);
            if (p == 2)
                hold_req = 1'b1;
            phase_start = tracker.transfers;
            while (tracker.transfers - phase_start < ITEMS_PER_PHASE
                   || tracker.phase != PH_IDLE) begin
                if (tracker.phase == PH_IDLE)
                    code = ($urandom_range(0, 4) == 0) ? OP_TICK : 2'($urandom_range(1, 3));
                else
                    code = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(1, 3)) : OP_TICK;
                send_item(make_item(code, SW_RANDOM));
            end
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("covered %0d bit periods: %0d reads, %0d writes, %0d line resets (%0d with switch)",
                 tracker.transfers, tracker.reads, tracker.writes, tracker.resets,
                 tracker.switch_resets);
        $display("checked %0d result transfers, %0d mismatches", tracker.checked, tracker.errors);
        if (tracker.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
